>>> src/i2p_pkg.sv
package i2p_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_RPAREN = 8'h29;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;

  typedef enum logic [2:0] {
    CODE_NONE   = 3'd0,
    CODE_PLUS   = 3'd1,
    CODE_MINUS  = 3'd2,
    CODE_STAR   = 3'd3,
    CODE_SLASH  = 3'd4,
    CODE_DOLLAR = 3'd5,
    CODE_LPAREN = 3'd6
  } code_t;

  typedef struct packed {
    logic  push;
    logic  pop;
    code_t code;
  } stk_ctl_t;

  function automatic code_t op_code(input logic [7:0] c);
    code_t r;
    unique case (c)
      CHAR_PLUS:   r = CODE_PLUS;
      CHAR_MINUS:  r = CODE_MINUS;
      CHAR_STAR:   r = CODE_STAR;
      CHAR_SLASH:  r = CODE_SLASH;
      CHAR_DOLLAR: r = CODE_DOLLAR;
      default:     r = CODE_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] code_char(input code_t code);
    logic [7:0] r;
    unique case (code)
      CODE_PLUS:   r = CHAR_PLUS;
      CODE_MINUS:  r = CHAR_MINUS;
      CODE_STAR:   r = CHAR_STAR;
      CODE_SLASH:  r = CHAR_SLASH;
      CODE_DOLLAR: r = CHAR_DOLLAR;
      CODE_LPAREN: r = CHAR_LPAREN;
      default:     r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] code_prec(input code_t code);
    logic [1:0] r;
    unique case (code)
      CODE_PLUS, CODE_MINUS: r = 2'd1;
      CODE_STAR, CODE_SLASH: r = 2'd2;
      CODE_DOLLAR:           r = 2'd3;
      default:               r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_operand(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

endpackage

>>> src/i2p_stack.sv
module i2p_stack import i2p_pkg::*; #(
  parameter int DEPTH = STACK_DEPTH_DEF,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  stk_ctl_t         ctl,
  output logic [CNT_W-1:0] count,
  output code_t            top
);

  code_t            mem [DEPTH];
  logic [CNT_W-1:0] cnt_dec;
  logic [IDX_W-1:0] rd_idx;

  assign cnt_dec = count - CNT_W'(1);
  assign rd_idx  = cnt_dec[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.push) begin
      count <= count + CNT_W'(1);
    end else if (ctl.pop) begin
      count <= cnt_dec;
    end
  end

  // write the new top; the current top is read through a register
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[count[IDX_W-1:0]] <= ctl.code;
    end
    top <= mem[rd_idx];
  end

endmodule

>>> src/infix_to_postfix_converter.sv
// Sequencing: an operand result is held back, then released to the output in
// FIN; each pop reads the registered top (READ), then compares and emits (TEST),
// and a push is done in PUSH. An operator pops, then pushes; '(' only pushes;
// ')' or end pops, and ')' also drops a matched '('. Output stalls can hold the
// sequencer while a result waits.
// Reset (rst, synchronous) empties the stack and idles the sequencer and output.
module infix_to_postfix_converter import i2p_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int CNT_W = $clog2(STACK_DEPTH + 1)
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic [7:0] character,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] symbol,
  output logic       last_of_run,
  output logic       stack_overflow
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_TEST = 5'b00100,
    ST_PUSH = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  // what the pop loop is doing for the current transaction
  typedef enum logic [2:0] {
    MODE_FLUSH = 3'b001,
    MODE_OPER  = 3'b010,
    MODE_CLOSE = 3'b100
  } mode_t;

  state_t           state, state_next;
  mode_t            mode, mode_next;
  code_t            new_code, new_code_next;

  // one result held back until we know whether another follows
  logic             pend_valid;
  logic [7:0]       pend_sym;
  logic             pend_ovf;

  logic             produce;
  logic [7:0]       prod_sym;
  logic             prod_ovf;
  logic             fin_emit;
  logic             out_free;
  logic             can_produce;
  logic             do_pop;
  code_t            char_code;

  stk_ctl_t         ctl;
  logic [CNT_W-1:0] stk_count;
  code_t            stk_top;
  logic [1:0]       top_prec;
  logic [1:0]       new_prec;

  i2p_stack #(
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .count(stk_count),
    .top  (stk_top)
  );

  assign in_ready    = (state == ST_IDLE);
  assign out_free    = !out_valid || out_ready;
  assign can_produce = !pend_valid || out_free;
  assign char_code   = op_code(character);
  assign top_prec    = code_prec(stk_top);
  assign new_prec    = code_prec(new_code);

  // pop decision for the stacked top against the current mode
  always_comb begin
    unique case (mode)
      MODE_FLUSH: do_pop = 1'b1;
      MODE_OPER:  do_pop = (stk_top != CODE_LPAREN) &&
                           ((top_prec > new_prec) ||
                            ((top_prec == new_prec) && (stk_top != CODE_DOLLAR)));
      MODE_CLOSE: do_pop = (stk_top != CODE_LPAREN);
      default:    do_pop = 1'b0;
    endcase
  end

  always_comb begin
    state_next    = state;
    mode_next     = mode;
    new_code_next = new_code;
    ctl           = '0;
    produce       = 1'b0;
    prod_sym      = 8'd0;
    prod_ovf      = 1'b0;
    fin_emit      = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (op) begin
            // end mark: flush everything
            mode_next  = MODE_FLUSH;
            state_next = (stk_count != '0) ? ST_READ : ST_IDLE;
          end else begin
            priority if ((character == CHAR_SPACE) || (character == CHAR_COMMA)) begin
              state_next = ST_IDLE;
            end else if (char_code != CODE_NONE) begin
              mode_next     = MODE_OPER;
              new_code_next = char_code;
              state_next    = (stk_count != '0) ? ST_READ : ST_PUSH;
            end else if (is_operand(character)) begin
              // pending is always empty here
              produce    = 1'b1;
              prod_sym   = character;
              state_next = ST_FIN;
            end else if (character == CHAR_LPAREN) begin
              new_code_next = CODE_LPAREN;
              state_next    = ST_PUSH;
            end else if (character == CHAR_RPAREN) begin
              // closing parenthesis on an empty stack is ignored
              mode_next  = MODE_CLOSE;
              state_next = (stk_count != '0) ? ST_READ : ST_IDLE;
            end else begin
              state_next = ST_IDLE;
            end
          end
        end
      end

      ST_READ: begin
        // wait for the registered top
        state_next = ST_TEST;
      end

      ST_TEST: begin
        if (do_pop) begin
          if (can_produce) begin
            produce  = 1'b1;
            prod_sym = code_char(stk_top);
            ctl.pop  = 1'b1;
            if (stk_count == CNT_W'(1)) begin
              state_next = (mode == MODE_OPER) ? ST_PUSH : ST_FIN;
            end else begin
              state_next = ST_READ;
            end
          end
        end else if (mode == MODE_CLOSE) begin
          // drop the matching '('
          ctl.pop    = 1'b1;
          state_next = ST_FIN;
        end else begin
          state_next = ST_PUSH;
        end
      end

      ST_PUSH: begin
        if (stk_count >= CNT_W'(STACK_DEPTH)) begin
          // full: drop the push and flag it
          if (can_produce) begin
            produce    = 1'b1;
            prod_ovf   = 1'b1;
            state_next = ST_FIN;
          end
        end else begin
          ctl.push   = 1'b1;
          ctl.code   = new_code;
          state_next = ST_FIN;
        end
      end

      ST_FIN: begin
        // release the held result as the last of the run
        if (pend_valid) begin
          if (out_free) begin
            fin_emit   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      mode       <= MODE_FLUSH;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      if (produce) begin
        pend_valid <= 1'b1;
      end else if (fin_emit) begin
        pend_valid <= 1'b0;
      end
      if ((produce && pend_valid) || fin_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    new_code <= new_code_next;
    if (produce) begin
      pend_sym <= prod_sym;
      pend_ovf <= prod_ovf;
    end
    // advance the held result to the output register
    if ((produce && pend_valid) || fin_emit) begin
      symbol         <= pend_sym;
      stack_overflow <= pend_ovf;
      last_of_run    <= fin_emit;
    end
  end

`ifndef SYNTHESIS
  a_ovf_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stack_overflow) |-> (symbol == 8'd0) && last_of_run)
    else $error("overflow result malformed");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("result held while idle");

  a_test_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TEST) |-> (stk_count != '0))
    else $error("stack test on empty stack");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> (stk_count < CNT_W'(STACK_DEPTH)))
    else $error("push onto full stack");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(symbol) &&
      $stable(last_of_run) && $stable(stack_overflow))
    else $error("result changed while stalled");
`endif

endmodule

>>> dv/infix_to_postfix_converter_tb.sv
module infix_to_postfix_converter_tb;
  import i2p_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH = STACK_DEPTH_DEF;
  // Longest correct silence: a long sender gap, a full flush of the stack and
  // a long receiver stall all fall well under STUCK_LIMIT.
  localparam int STUCK_LIMIT = 2000;
  localparam int LIVE_TARGET = 390;
  localparam int DRAIN_CYCLES = 100;

  // One postfix symbol as the block presents it.
  typedef struct {
    logic [7:0] sym;
    logic       last;
    logic       ovf;
  } postfix_sym_t;

  // One row of the directed stimulus. Rows marked typed carry their result
  // as written here; all other rows are checked against the predictor.
  typedef struct {
    logic       end_mark;
    logic [7:0] ch;
    int         reps;
    bit         typed;
    bit         has_res;
    logic [7:0] t_sym;
    logic       t_ovf;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       op = 1'b0;
  logic [7:0] character = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] symbol;
  logic       last_of_run;
  logic       stack_overflow;

  // Predictor state: pending operators, and the symbols still owed by the block.
  code_t        op_stack [STACK_DEPTH];
  int           op_depth = 0;
  postfix_sym_t step_syms [$];
  postfix_sym_t postfix_q [$];
  dir_row_t     dir_rows [$];

  int errors = 0;
  int live_items = 0;
  int stuck = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int out_stall = 0;

  infix_to_postfix_converter i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .character     (character),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .symbol        (symbol),
    .last_of_run   (last_of_run),
    .stack_overflow(stack_overflow)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Character classes and operator ranks
  // ---------------------------------------------------------------------------
  function automatic code_t code_of(input logic [7:0] c);
    case (c)
      CHAR_PLUS:   return CODE_PLUS;
      CHAR_MINUS:  return CODE_MINUS;
      CHAR_STAR:   return CODE_STAR;
      CHAR_SLASH:  return CODE_SLASH;
      CHAR_DOLLAR: return CODE_DOLLAR;
      default:     return CODE_NONE;
    endcase
  endfunction

  function automatic logic [1:0] rank_of(input code_t k);
    case (k)
      CODE_PLUS, CODE_MINUS: return 2'd1;
      CODE_STAR, CODE_SLASH: return 2'd2;
      CODE_DOLLAR:           return 2'd3;
      default:               return 2'd0;
    endcase
  endfunction

  function automatic logic [7:0] glyph_of(input code_t k);
    case (k)
      CODE_PLUS:   return CHAR_PLUS;
      CODE_MINUS:  return CHAR_MINUS;
      CODE_STAR:   return CHAR_STAR;
      CODE_SLASH:  return CHAR_SLASH;
      CODE_DOLLAR: return CHAR_DOLLAR;
      CODE_LPAREN: return CHAR_LPAREN;
      default:     return 8'h00;
    endcase
  endfunction

  function automatic bit is_alnum(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // ---------------------------------------------------------------------------
  // Shunting-yard predictor: fills step_syms with what one transaction releases
  // ---------------------------------------------------------------------------
  function automatic void pop_operator();
    op_depth--;
    step_syms.push_back('{glyph_of(op_stack[op_depth]), 1'b0, 1'b0});
  endfunction

  // A push onto a full stack is dropped and flagged with a lone error symbol.
  function automatic void push_operator(input code_t k);
    if (op_depth >= STACK_DEPTH) begin
      step_syms.push_back('{8'h00, 1'b0, 1'b1});
    end else begin
      op_stack[op_depth] = k;
      op_depth++;
    end
  endfunction

  function automatic void predict_postfix(input logic end_mark, input logic [7:0] c);
    code_t nc;
    code_t top;
    step_syms.delete();
    nc = code_of(c);
    if (end_mark) begin
      // Flush everything, unmatched '(' included, top first.
      while (op_depth > 0) pop_operator();
    end else if (c == CHAR_SPACE || c == CHAR_COMMA) begin
      // skipped
    end else if (nc != CODE_NONE) begin
      // Pop while the top binds tighter; '$' on top of '$' stays (right assoc).
      while (op_depth > 0) begin
        top = op_stack[op_depth-1];
        if (top == CODE_LPAREN) break;
        if (!(rank_of(top) > rank_of(nc) ||
              (rank_of(top) == rank_of(nc) && top != CODE_DOLLAR))) break;
        pop_operator();
      end
      push_operator(nc);
    end else if (is_alnum(c)) begin
      step_syms.push_back('{c, 1'b0, 1'b0});
    end else if (c == CHAR_LPAREN) begin
      push_operator(CODE_LPAREN);
    end else if (c == CHAR_RPAREN) begin
      // Unmatched ')' just empties the stack; on an empty stack it does nothing.
      while (op_depth > 0 && op_stack[op_depth-1] != CODE_LPAREN) pop_operator();
      if (op_depth > 0) op_depth--;
    end
    if (step_syms.size() > 0) step_syms[step_syms.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  function automatic void add_row(input logic e, input logic [7:0] c, input int reps,
                                  input bit typed, input bit has_res,
                                  input logic [7:0] s, input logic ovf);
    dir_rows.push_back('{e, c, reps, typed, has_res, s, ovf});
  endfunction

  function automatic void add_pred(input logic e, input logic [7:0] c);
    add_row(e, c, 1, 1'b0, 1'b0, 8'h00, 1'b0);
  endfunction

  // ---------------------------------------------------------------------------
  // Gap lengths: mostly short, now and then long
  // ---------------------------------------------------------------------------
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: hold valid and payload until the transaction is taken, then predict
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic e, input logic [7:0] c, input bit typed,
                           input bit has_res, input logic [7:0] s, input logic ovf);
    int gap;
    gap = (in_calm || $urandom_range(0, 99) < 50) ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    op        = e;
    character = c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_postfix(e, c);
    if (typed) begin
      // Take the written-in result; the predictor only tracks the stack here.
      if (has_res) postfix_q.push_back('{s, 1'b1, ovf});
    end else begin
      foreach (step_syms[i]) postfix_q.push_back(step_syms[i]);
    end
    live_items++;
  endtask

  task automatic send_char(input logic [7:0] c);
    send_item(1'b0, c, 1'b0, 1'b0, 8'h00, 1'b0);
  endtask

  task automatic send_end();
    send_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 8'h00, 1'b0);
  endtask

  function automatic logic [7:0] rand_operand();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("a" + r - 10);
    return 8'("A" + r - 36);
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 5))
      0:       return CHAR_PLUS;
      1:       return CHAR_MINUS;
      2:       return CHAR_STAR;
      3:       return CHAR_SLASH;
      default: return CHAR_DOLLAR;
    endcase
  endfunction

  // Sprinkle the odd space or comma between tokens.
  task automatic maybe_blank();
    if ($urandom_range(0, 9) == 0) send_char($urandom_range(0, 1) ? CHAR_SPACE : CHAR_COMMA);
  endtask

  // Well-formed expression with random operands, operators and nesting.
  task automatic send_expression();
    int n_terms;
    int opens;
    n_terms = $urandom_range(1, 10);
    opens = 0;
    for (int i = 0; i < n_terms; i++) begin
      while (opens < 6 && $urandom_range(0, 3) == 0) begin
        maybe_blank();
        send_char(CHAR_LPAREN);
        opens++;
      end
      maybe_blank();
      send_char(rand_operand());
      while (opens > 0 && $urandom_range(0, 2) == 0) begin
        send_char(CHAR_RPAREN);
        opens--;
      end
      if (i < n_terms - 1) begin
        maybe_blank();
        send_char(rand_operator());
      end
    end
    // Leave some '(' unmatched so the end mark has to flush them.
    if ($urandom_range(0, 9) < 8) begin
      while (opens > 0) begin
        send_char(CHAR_RPAREN);
        opens--;
      end
    end
    send_end();
  endtask

  // Any byte, stray parentheses and early end marks.
  task automatic send_noise();
    int r;
    repeat ($urandom_range(3, 12)) begin
      r = $urandom_range(0, 99);
      if (r < 40)      send_char(8'($urandom_range(0, 255)));
      else if (r < 60) send_char(CHAR_RPAREN);
      else if (r < 70) send_char(CHAR_LPAREN);
      else if (r < 85) send_char(rand_operand());
      else if (r < 95) send_char(rand_operator());
      else             send_end();
    end
  endtask

  // Deep nesting that fills the stack, often past full, then a full flush.
  task automatic send_deep();
    repeat ($urandom_range(28, 36)) begin
      if ($urandom_range(0, 3) == 0) begin
        send_char(rand_operand());
        send_char(CHAR_DOLLAR);
      end else begin
        send_char(CHAR_LPAREN);
      end
    end
    send_end();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, with calm stretches of constant ready
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 399) == 0) out_calm = ~out_calm;
      if (out_stall > 0) begin
        out_ready = 1'b0;
        out_stall--;
      end else begin
        out_ready = 1'b1;
        if (!out_calm && $urandom_range(0, 99) < 30) out_stall = idle_len();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each accepted symbol with the oldest one owed
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    postfix_sym_t want;
    if (!rst && out_valid && out_ready) begin
      if (postfix_q.size() == 0) begin
        errors++;
        $display("%0t ns: expected no symbol, got symbol %02h last %b overflow %b",
                 $time, symbol, last_of_run, stack_overflow);
      end else begin
        want = postfix_q.pop_front();
        if (symbol !== want.sym) begin
          errors++;
          $display("%0t ns: symbol expected %02h got %02h", $time, want.sym, symbol);
        end
        if (last_of_run !== want.last) begin
          errors++;
          $display("%0t ns: last_of_run expected %b got %b", $time, want.last, last_of_run);
        end
        if (stack_overflow !== want.ovf) begin
          errors++;
          $display("%0t ns: stack_overflow expected %b got %b",
                   $time, want.ovf, stack_overflow);
        end
      end
    end
  end

  // Watchdog: count cycles in which neither side moves a transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int r;

    // After reset: everything that leaves an empty stack silent.
    add_row(1'b1, 8'h00,       1, 1'b1, 1'b0, 8'h00, 1'b0);
    add_row(1'b0, CHAR_RPAREN, 1, 1'b1, 1'b0, 8'h00, 1'b0);
    add_row(1'b0, CHAR_SPACE,  1, 1'b1, 1'b0, 8'h00, 1'b0);
    add_row(1'b0, CHAR_COMMA,  1, 1'b1, 1'b0, 8'h00, 1'b0);
    add_row(1'b0, 8'h00,       1, 1'b1, 1'b0, 8'h00, 1'b0);
    add_row(1'b0, 8'hFF,       1, 1'b1, 1'b0, 8'h00, 1'b0);
    // Operands at the ends of their ranges pass straight through.
    add_row(1'b0, "0", 1, 1'b1, 1'b1, "0", 1'b0);
    add_row(1'b0, "z", 1, 1'b1, 1'b1, "z", 1'b0);
    add_row(1'b0, "A", 1, 1'b1, 1'b1, "A", 1'b0);
    add_row(1'b0, "Z", 1, 1'b1, 1'b1, "Z", 1'b0);
    // (a+b)*c$d$e/f-g) then end: every operator, a '$' chain, a ')' with no
    // matching '(' and an end mark whose character is ignored.
    add_pred(1'b0, CHAR_LPAREN);
    add_pred(1'b0, "a");
    add_pred(1'b0, CHAR_PLUS);
    add_pred(1'b0, "b");
    add_pred(1'b0, CHAR_RPAREN);
    add_pred(1'b0, CHAR_STAR);
    add_pred(1'b0, "c");
    add_pred(1'b0, CHAR_DOLLAR);
    add_pred(1'b0, "d");
    add_pred(1'b0, CHAR_DOLLAR);
    add_pred(1'b0, "e");
    add_pred(1'b0, CHAR_SLASH);
    add_pred(1'b0, "f");
    add_pred(1'b0, CHAR_MINUS);
    add_pred(1'b0, "g");
    add_pred(1'b0, CHAR_RPAREN);
    add_pred(1'b1, 8'hFF);
    // Fill the stack, then push '(' and an operator onto it while full.
    add_row(1'b0, CHAR_LPAREN, STACK_DEPTH, 1'b1, 1'b0, 8'h00, 1'b0);
    add_row(1'b0, CHAR_LPAREN, 1, 1'b1, 1'b1, 8'h00, 1'b1);
    add_row(1'b0, CHAR_DOLLAR, 1, 1'b1, 1'b1, 8'h00, 1'b1);
    add_pred(1'b1, 8'h00);

    // Hold reset, then release it away from the sampling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      repeat (dir_rows[i].reps)
        send_item(dir_rows[i].end_mark, dir_rows[i].ch, dir_rows[i].typed,
                  dir_rows[i].has_res, dir_rows[i].t_sym, dir_rows[i].t_ovf);
    end

    // Random part: mostly well-formed expressions, some noise, some overflow.
    live_items = 0;
    while (live_items < LIVE_TARGET) begin
      in_calm = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 99);
      if (r < 8)       send_deep();
      else if (r < 20) send_noise();
      else             send_expression();
    end

    // Drop valid, drain what is owed, then watch for strays.
    @(negedge clk);
    in_valid = 1'b0;
    while (postfix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
src/i2p_pkg.sv
src/i2p_stack.sv
src/infix_to_postfix_converter.sv
dv/infix_to_postfix_converter_tb.sv
